// File: src/fpa_pkg.sv
// fpa_pkg: shared types, constants and command codes of the fixed-point ALU
// no dependencies; used by the interfaces and by every module
`default_nettype none
package fpa_pkg;

   localparam int IO_WIDTH      = 32;
   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 8;

   // divider: one quotient bit per step, DIV_BITS steps per pipeline stage
   localparam int DIV_N       = DATA_WIDTH + FRACTION_BITS;
   localparam int DIV_BITS    = 2;
   localparam int DIV_STAGES  = (DIV_N + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_IDX_W   = (DIV_STAGES > 1) ? $clog2(DIV_STAGES) : 1;

   typedef enum logic [3:0] {
      CMD_ADD    = 4'd0,
      CMD_SUB    = 4'd1,
      CMD_MUL    = 4'd2,
      CMD_DIV    = 4'd3,
      CMD_GT     = 4'd4,
      CMD_LT     = 4'd5,
      CMD_GE     = 4'd6,
      CMD_LE     = 4'd7,
      CMD_EQ     = 4'd8,
      CMD_NE     = 4'd9,
      CMD_MIN    = 4'd10,
      CMD_MAX    = 4'd11,
      CMD_INC    = 4'd12,
      CMD_DEC    = 4'd13,
      CMD_TO_INT = 4'd14
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic                    neg;
      logic                    dz;
      logic                    cmp;
      logic [DATA_WIDTH-1:0]   res;
      logic [DATA_WIDTH-1:0]   ua;
      logic [DATA_WIDTH-1:0]   ub;
   } pre_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic                    neg;
      logic                    dz;
      logic                    cmp;
      logic [DATA_WIDTH-1:0]   res;
      logic [DATA_WIDTH-1:0]   ub;
      logic [DATA_WIDTH-1:0]   rem;
      logic [DIV_N-1:0]        dq;
   } div_type;

endpackage
`default_nettype wire

// File: src/fpa_req_if.sv
// fpa_req_if: request channel of the fixed-point ALU
// depends on fpa_pkg
`default_nettype none
interface fpa_req_if;
   import fpa_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [3:0]                 command;
   logic signed [IO_WIDTH-1:0] operand_a;
   logic signed [IO_WIDTH-1:0] operand_b;
   modport source (output valid, output command, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input command, input operand_a, input operand_b,
                   output ready);
endinterface
`default_nettype wire

// File: src/fpa_rsp_if.sv
// fpa_rsp_if: response channel of the fixed-point ALU
// depends on fpa_pkg
`default_nettype none
interface fpa_rsp_if;
   import fpa_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] result;
   logic                       compare_true;
   logic                       divide_by_zero;
   modport source (output valid, output result, output compare_true,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input result, input compare_true,
                   input divide_by_zero, output ready);
endinterface
`default_nettype wire

// File: src/fpa_prep.sv
// fpa_prep: first pipeline stage; decodes a request, forms magnitudes and
// the results of all commands except multiply and divide. depends on fpa_pkg
`default_nettype none
module fpa_prep (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            in_valid,
   input  wire logic [3:0]                      in_command,
   input  wire logic [fpa_pkg::IO_WIDTH-1:0]    in_a,
   input  wire logic [fpa_pkg::IO_WIDTH-1:0]    in_b,
   output      logic                            out_valid,
   output      fpa_pkg::pre_type                out_data
);
   import fpa_pkg::*;

   logic                          valid_ff;
   pre_type                       data_ff;
   pre_type                       data_in;
   logic signed [DATA_WIDTH-1:0]  a_s;
   logic signed [DATA_WIDTH-1:0]  b_s;
   cmd_type                       cmd;

   always_comb begin
      a_s = signed'(in_a[DATA_WIDTH-1:0]);
      b_s = signed'(in_b[DATA_WIDTH-1:0]);
      cmd = cmd_type'(in_command);
      data_in.cmd = cmd;
      data_in.neg = a_s[DATA_WIDTH-1] ^ b_s[DATA_WIDTH-1];
      data_in.ua  = a_s[DATA_WIDTH-1] ? DATA_WIDTH'(-a_s) : DATA_WIDTH'(a_s);
      data_in.ub  = b_s[DATA_WIDTH-1] ? DATA_WIDTH'(-b_s) : DATA_WIDTH'(b_s);
      data_in.dz  = (cmd == CMD_DIV) && (b_s == '0);
      data_in.cmp = 1'b0;
      data_in.res = '0;
      case (cmd)
         CMD_ADD:    data_in.res = DATA_WIDTH'(a_s + b_s);
         CMD_SUB:    data_in.res = DATA_WIDTH'(a_s - b_s);
         CMD_GT:     data_in.cmp = (a_s > b_s);
         CMD_LT:     data_in.cmp = (a_s < b_s);
         CMD_GE:     data_in.cmp = (a_s >= b_s);
         CMD_LE:     data_in.cmp = (a_s <= b_s);
         CMD_EQ:     data_in.cmp = (a_s == b_s);
         CMD_NE:     data_in.cmp = (a_s != b_s);
         CMD_MIN:    data_in.res = (a_s < b_s) ? a_s : b_s;
         CMD_MAX:    data_in.res = (a_s > b_s) ? a_s : b_s;
         CMD_INC:    data_in.res = DATA_WIDTH'(a_s + 1);
         CMD_DEC:    data_in.res = DATA_WIDTH'(a_s - 1);
         CMD_TO_INT: data_in.res = DATA_WIDTH'(a_s >>> FRACTION_BITS);
         default:    data_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// File: src/fpa_div_stage.sv
// fpa_div_stage: one stage of the restoring divider, up to DIV_BITS quotient bits per stage
// depends on fpa_pkg
`default_nettype none
module fpa_div_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic [fpa_pkg::DIV_IDX_W-1:0]    stage_index,
   input  wire logic                             in_valid,
   input  wire fpa_pkg::div_type                 in_data,
   output      logic                             out_valid,
   output      fpa_pkg::div_type                 out_data
);
   import fpa_pkg::*;

   logic                    valid_ff;
   div_type                 data_ff;
   div_type                 data_in;
   logic [DATA_WIDTH:0]     trial;
   logic [DATA_WIDTH-1:0]   rem;
   logic [DIV_N-1:0]        dq;

   always_comb begin
      rem   = in_data.rem;
      dq    = in_data.dq;
      trial = '0;
      for (int j = 0; j < DIV_BITS; j++) begin
         if (int'(stage_index) * DIV_BITS + j < DIV_N) begin
            trial = {rem, dq[DIV_N-1]};
            dq    = {dq[DIV_N-2:0], 1'b0};
            if (trial >= {1'b0, in_data.ub}) begin
               trial = trial - {1'b0, in_data.ub};
               dq[0] = 1'b1;
            end
            rem = trial[DATA_WIDTH-1:0];
         end
      end
      data_in     = in_data;
      data_in.rem = rem;
      data_in.dq  = dq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// File: src/fixed_point_alu_unit.sv
// fixed_point_alu_unit: pipelined signed fixed-point ALU, top level
// depends on fpa_pkg, fpa_req_if, fpa_rsp_if, fpa_prep, fpa_div_stage
//
// channel    | direction | contents
// req_chan   | in        | command, operand_a, operand_b
// rsp_chan   | out       | result, compare_true, divide_by_zero
//
// one request per cycle unless the output stalls; the restoring divider resolves
// two quotient bits per pipeline stage
// reset clears every valid bit at once; no clearing pass
// a response held on the output stalls the whole pipeline in place
`default_nettype none
module fixed_point_alu_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   fpa_req_if.sink   req_chan,
   fpa_rsp_if.source rsp_chan
);
   import fpa_pkg::*;

   logic                        advance;
   logic                        pre_valid;
   pre_type                     pre_data;

   logic                        mul_valid_ff;
   logic [2*DATA_WIDTH-1:0]     prod_ff;
   div_type                     mul_data_ff;
   div_type                     mul_data_in;

   logic                        fold_valid_ff;
   div_type                     fold_data_ff;
   div_type                     fold_data_in;
   logic [DATA_WIDTH-1:0]       mul_mag;

   logic    div_valid [DIV_STAGES+1];
   div_type div_data  [DIV_STAGES+1];

   logic                        out_valid_ff;
   logic [IO_WIDTH-1:0]         out_result_ff;
   logic [IO_WIDTH-1:0]         out_result_in;
   logic                        out_cmp_ff;
   logic                        out_dz_ff;
   logic [DATA_WIDTH-1:0]       quot;
   logic [DATA_WIDTH-1:0]       final_res;
   div_type                     last;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   fpa_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_chan.valid),
      .in_command (req_chan.command),
      .in_a       (req_chan.operand_a),
      .in_b       (req_chan.operand_b),
      .out_valid  (pre_valid),
      .out_data   (pre_data)
   );

   // multiply stage, also loads the divider's dividend
   always_comb begin
      mul_data_in.cmd = pre_data.cmd;
      mul_data_in.neg = pre_data.neg;
      mul_data_in.dz  = pre_data.dz;
      mul_data_in.cmp = pre_data.cmp;
      mul_data_in.res = pre_data.res;
      mul_data_in.ub  = pre_data.ub;
      mul_data_in.rem = '0;
      mul_data_in.dq  = {pre_data.ua, {FRACTION_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= pre_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff     <= pre_data.ua * pre_data.ub;
         mul_data_ff <= mul_data_in;
      end
   end

   // product scaling and sign
   always_comb begin
      mul_mag      = prod_ff[FRACTION_BITS +: DATA_WIDTH];
      fold_data_in = mul_data_ff;
      if (mul_data_ff.cmd == CMD_MUL) begin
         fold_data_in.res = mul_data_ff.neg ? DATA_WIDTH'(-mul_mag) : mul_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_data_ff <= fold_data_in;
      end
   end

   assign div_valid[0] = fold_valid_ff;
   assign div_data[0]  = fold_data_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      fpa_div_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .stage_index (DIV_IDX_W'(s)),
         .in_valid    (div_valid[s]),
         .in_data     (div_data[s]),
         .out_valid   (div_valid[s+1]),
         .out_data    (div_data[s+1])
      );
   end

   // result select
   always_comb begin
      last = div_data[DIV_STAGES];
      quot = last.dq[DATA_WIDTH-1:0];
      case (last.cmd)
         CMD_DIV: begin
            if (last.dz) begin
               final_res = '0;
            end else begin
               final_res = last.neg ? DATA_WIDTH'(-quot) : quot;
            end
         end
         default: final_res = last.res;
      endcase
      out_result_in = IO_WIDTH'(signed'(final_res));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= out_result_in;
         out_cmp_ff    <= last.cmp;
         out_dz_ff     <= last.dz;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.result         = signed'(out_result_ff);
   assign rsp_chan.compare_true   = out_cmp_ff;
   assign rsp_chan.divide_by_zero = out_dz_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while output stalled");

   a_dz_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.divide_by_zero) |->
         (rsp_chan.result == '0 && !rsp_chan.compare_true))
      else $error("divide by zero with nonzero result");

   a_cmp_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.compare_true) |-> (rsp_chan.result == '0))
      else $error("comparison with nonzero result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !pre_valid && !mul_valid_ff))
      else $error("valid bits not cleared by reset");
endmodule
`default_nettype wire
